/* hdl/tllw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllw_pkg
// Shared types, codes and constants of the text line layout block.
// ----------------------------------------------------------------------------
package tllw_pkg;

   // default position width of the pen state
   localparam int POS_BITS_DEF = 24;

   // widths of the external fields
   localparam int OUT_W  = 24;
   localparam int CODE_W = 21;
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // result queue depth
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);

   // request kinds
   localparam logic [1:0] KIND_CHAR    = 2'd0;
   localparam logic [1:0] KIND_NEWLINE = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   // result kinds
   localparam logic [1:0] RES_GLYPH  = 2'd0;
   localparam logic [1:0] RES_LINE   = 2'd1;
   localparam logic [1:0] RES_REGION = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_CHAR_WIDTH  = 3'd0;
   localparam logic [2:0] REG_LINE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_SPACING_X   = 3'd2;
   localparam logic [2:0] REG_SPACING_Y   = 3'd3;
   localparam logic [2:0] REG_AREA_WIDTH  = 3'd4;
   localparam logic [2:0] REG_AREA_HEIGHT = 3'd5;
   localparam logic [2:0] REG_WIDTH_SCALE = 3'd6;
   localparam logic [2:0] REG_LAYOUT_MODE = 3'd7;

   // layout mode bits
   localparam int MODE_WRAP = 0;
   localparam int MODE_CLIP = 1;

   // configuration seen by the layout engine
   typedef struct packed {
      logic        [15:0] char_width;
      logic        [15:0] line_height;
      logic signed [15:0] spacing_x;
      logic signed [15:0] spacing_y;
      logic        [22:0] area_width;
      logic        [22:0] area_height;
      logic        [15:0] width_scale;
      logic        [1:0]  layout_mode;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic        [1:0]        kind_res;
      logic        [CODE_W-1:0] glyph_code;
      logic signed [OUT_W-1:0]  pos_x;
      logic signed [OUT_W-1:0]  pos_y;
      logic signed [OUT_W-1:0]  extent_width;
      logic signed [OUT_W-1:0]  extent_height;
      logic                     last;
   } res_type;

   // results produced by one request, packed from the front
   typedef struct packed {
      logic [1:0] cnt;
      res_type    r0;
      res_type    r1;
   } push_type;

endpackage
`default_nettype wire

/* hdl/tllw_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllw_csr
// APB-style register file holding the layout configuration.
// ----------------------------------------------------------------------------
module tllw_csr
   import tllw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic      [DATA_W-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign cfg     = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.char_width  <= 16'd256;
         cfg_ff.line_height <= 16'd256;
         cfg_ff.spacing_x   <= '0;
         cfg_ff.spacing_y   <= '0;
         cfg_ff.area_width  <= 23'd4096;
         cfg_ff.area_height <= 23'd4096;
         cfg_ff.width_scale <= 16'd256;
         cfg_ff.layout_mode <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_CHAR_WIDTH:  cfg_ff.char_width  <= pwdata[15:0];
            REG_LINE_HEIGHT: cfg_ff.line_height <= pwdata[15:0];
            REG_SPACING_X:   cfg_ff.spacing_x   <= pwdata[15:0];
            REG_SPACING_Y:   cfg_ff.spacing_y   <= pwdata[15:0];
            REG_AREA_WIDTH:  cfg_ff.area_width  <= pwdata[22:0];
            REG_AREA_HEIGHT: cfg_ff.area_height <= pwdata[22:0];
            REG_WIDTH_SCALE: cfg_ff.width_scale <= pwdata[15:0];
            REG_LAYOUT_MODE: cfg_ff.layout_mode <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_CHAR_WIDTH:  prdata = {16'd0, cfg_ff.char_width};
         REG_LINE_HEIGHT: prdata = {16'd0, cfg_ff.line_height};
         REG_SPACING_X:   prdata = {16'd0, cfg_ff.spacing_x};
         REG_SPACING_Y:   prdata = {16'd0, cfg_ff.spacing_y};
         REG_AREA_WIDTH:  prdata = {9'd0, cfg_ff.area_width};
         REG_AREA_HEIGHT: prdata = {9'd0, cfg_ff.area_height};
         REG_WIDTH_SCALE: prdata = {16'd0, cfg_ff.width_scale};
         REG_LAYOUT_MODE: prdata = {30'd0, cfg_ff.layout_mode};
         default:         prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

/* hdl/tllw_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllw_engine
// Request register, pen state and the per-request layout step.
// ----------------------------------------------------------------------------
module tllw_engine
   import tllw_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  cfg_type                cfg,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_kind,
   input  wire logic [CODE_W-1:0] req_glyph_code,
   input  wire logic              req_glyph_known,
   input  wire logic [15:0]       req_glyph_trim_width,
   input  wire logic              room,
   output push_type               push
);

   // exact sums need room for the 25-bit scaled advance plus signs
   localparam int SW = POS_BITS + 12;
   localparam logic signed [SW-1:0] POS_MAX = SW'((longint'(1) <<< (POS_BITS - 1)) - 1);
   localparam logic signed [SW-1:0] POS_MIN = ~POS_MAX;

   typedef logic signed [POS_BITS-1:0] pos_type;

   function automatic pos_type sat_pos(input logic signed [SW-1:0] v);
      pos_type r;
      if (v > POS_MAX) begin
         r = POS_BITS'(POS_MAX);
      end else if (v < POS_MIN) begin
         r = POS_BITS'(POS_MIN);
      end else begin
         r = POS_BITS'(v);
      end
      return r;
   endfunction

   function automatic logic signed [OUT_W-1:0] to_out(input pos_type v);
      return OUT_W'(v);
   endfunction

   // request register
   logic              item_valid_ff;
   logic [1:0]        item_kind_ff;
   logic [CODE_W-1:0] item_code_ff;
   logic              item_known_ff;
   logic [15:0]       item_trim_ff;

   // pen state
   pos_type pen_x_ff, pen_x_in;
   pos_type pen_y_ff, pen_y_in;
   pos_type widest_ff, widest_in;
   logic    has_glyph_ff, has_glyph_in;
   logic    stopped_ff, stopped_in;

   logic consume;
   logic load;

   // step datapath
   logic        [32:0]   prod;
   logic signed [SW-1:0] sx_s, sy_s, lh_s, cw_s, aw_s, ah_s, px_s, py_s;
   logic signed [SW-1:0] adv_s;
   logic                 wrap_hit, drop0, drop1;
   pos_type              line_w, py_next_line, widest_upd;
   pos_type              px_char, py_char, new_px, py_end;
   logic                 line_vld, sec_vld;
   res_type              line_res, sec_res;

   assign consume   = item_valid_ff & room;
   assign req_ready = ~item_valid_ff | consume;
   assign load      = req_valid & req_ready;

   // operands
   always_comb begin
      sx_s = SW'(cfg.spacing_x);
      sy_s = SW'(cfg.spacing_y);
      lh_s = SW'(cfg.line_height);
      cw_s = SW'(cfg.char_width);
      aw_s = SW'(cfg.area_width);
      ah_s = SW'(cfg.area_height);
      px_s = SW'(pen_x_ff);
      py_s = SW'(pen_y_ff);
   end

   // glyph advance: round(trim * scale / 256) + spacing, else char width + spacing
   assign prod  = 33'(item_trim_ff) * 33'(cfg.width_scale) + 33'd128;
   assign adv_s = item_known_ff ? (SW'(prod[32:8]) + sx_s) : (cw_s + sx_s);

   // line close terms
   assign wrap_hit     = cfg.layout_mode[MODE_WRAP] && (px_s + adv_s > aw_s);
   assign drop0        = cfg.layout_mode[MODE_CLIP] && (py_s + lh_s > ah_s);
   assign line_w       = has_glyph_ff ? sat_pos(px_s - sx_s) : pen_x_ff;
   assign py_next_line = sat_pos(py_s + lh_s + sy_s);
   assign widest_upd   = (line_w > widest_ff) ? line_w : widest_ff;

   // character placement after a possible wrap
   assign px_char = wrap_hit ? '0 : pen_x_ff;
   assign py_char = wrap_hit ? py_next_line : pen_y_ff;
   assign drop1   = cfg.layout_mode[MODE_CLIP] && (SW'(py_char) + lh_s > ah_s);
   assign new_px  = sat_pos(SW'(px_char) + adv_s);

   // pen y after end-of-text close
   assign py_end = (!stopped_ff && !drop0) ? py_next_line : pen_y_ff;

   // step control
   always_comb begin
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      widest_in    = widest_ff;
      has_glyph_in = has_glyph_ff;
      stopped_in   = stopped_ff;
      line_vld     = 1'b0;
      sec_vld      = 1'b0;

      line_res              = '0;
      line_res.kind_res     = RES_LINE;
      line_res.pos_y        = to_out(pen_y_ff);
      line_res.extent_width = to_out(line_w);

      sec_res            = '0;
      sec_res.kind_res   = RES_GLYPH;
      sec_res.glyph_code = item_code_ff;
      sec_res.pos_x      = to_out(px_char);
      sec_res.pos_y      = to_out(py_char);

      case (item_kind_ff)
         KIND_CHAR: begin
            if (!stopped_ff) begin
               if (wrap_hit && drop0) begin
                  stopped_in = 1'b1;
               end else begin
                  if (wrap_hit) begin
                     line_vld  = 1'b1;
                     widest_in = widest_upd;
                  end
                  has_glyph_in = wrap_hit ? 1'b0 : has_glyph_ff;
                  if (item_known_ff) begin
                     has_glyph_in = 1'b1;
                     sec_vld      = !drop1;
                  end
                  pen_x_in = new_px;
                  pen_y_in = py_char;
               end
            end
         end
         KIND_NEWLINE: begin
            if (!stopped_ff) begin
               if (drop0) begin
                  stopped_in = 1'b1;
               end else begin
                  line_vld     = 1'b1;
                  widest_in    = widest_upd;
                  pen_x_in     = '0;
                  pen_y_in     = py_next_line;
                  has_glyph_in = 1'b0;
               end
            end
         end
         KIND_END: begin
            line_vld                  = !stopped_ff && !drop0;
            sec_vld                   = 1'b1;
            sec_res                   = '0;
            sec_res.kind_res          = RES_REGION;
            sec_res.extent_width      = to_out(line_vld ? widest_upd : widest_ff);
            sec_res.extent_height     = to_out(sat_pos(SW'(py_end) - sy_s));
            pen_x_in                  = '0;
            pen_y_in                  = '0;
            widest_in                 = '0;
            has_glyph_in              = 1'b0;
            stopped_in                = 1'b0;
         end
         default: ;
      endcase

      sec_res.last  = 1'b1;
      line_res.last = !sec_vld;
   end

   // pack results toward the front of the push
   always_comb begin
      push.cnt = 2'(line_vld) + 2'(sec_vld);
      push.r0  = line_vld ? line_res : sec_res;
      push.r1  = sec_res;
      if (!consume) begin
         push.cnt = 2'd0;
      end
   end

   // request register and state update
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         pen_x_ff      <= '0;
         pen_y_ff      <= '0;
         widest_ff     <= '0;
         has_glyph_ff  <= 1'b0;
         stopped_ff    <= 1'b0;
      end else begin
         if (load) begin
            item_valid_ff <= 1'b1;
         end else if (consume) begin
            item_valid_ff <= 1'b0;
         end
         if (consume) begin
            pen_x_ff     <= pen_x_in;
            pen_y_ff     <= pen_y_in;
            widest_ff    <= widest_in;
            has_glyph_ff <= has_glyph_in;
            stopped_ff   <= stopped_in;
         end
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (load) begin
         item_kind_ff  <= req_kind;
         item_code_ff  <= req_glyph_code;
         item_known_ff <= req_glyph_known;
         item_trim_ff  <= req_glyph_trim_width;
      end
   end

endmodule
`default_nettype wire

/* hdl/tllw_rsp_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tllw_rsp_fifo
// Small result queue taking up to two results per cycle, giving one.
// ----------------------------------------------------------------------------
module tllw_rsp_fifo
   import tllw_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  push_type  push,
   output logic      room,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output res_type   rsp
);

   res_type                entries_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff;
   logic [RSP_PTR_W:0]     count_ff;
   logic                   pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & rsp_ready;
   assign room      = (count_ff <= (RSP_PTR_W + 1)'(RSP_DEPTH - 2));
   assign rsp       = entries_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + RSP_PTR_W'(push.cnt);
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (RSP_PTR_W + 1)'(push.cnt) - (RSP_PTR_W + 1)'(pop);
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.cnt == 2'd2) begin
         entries_ff[wr_ptr_ff + 1'b1] <= push.r1;
      end
   end

endmodule
`default_nettype wire

/* hdl/text_line_layout_wrap_clip.sv */
// A request is registered on acceptance and its results enter the result queue
// when the engine consumes it, which waits until the queue has room for two results.
// Throughput: one request per cycle while the queue has room and each gives at most
// one result; a request that closes a line and places a glyph uses the single result port twice.
// Reset (synchronous, active high) clears the pen state, the queue and restores
// all configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_layout_wrap_clip
// Greedy text line layout with wrap at area width and clip below area height.
// ----------------------------------------------------------------------------
module text_line_layout_wrap_clip
   import tllw_pkg::*;
#(
   parameter int POS_BITS = POS_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_kind,
   input  wire logic [CODE_W-1:0]       req_glyph_code,
   input  wire logic                    req_glyph_known,
   input  wire logic [15:0]             req_glyph_trim_width,
   // result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_kind_res,
   output logic [CODE_W-1:0]            rsp_glyph_code_res,
   output logic signed [OUT_W-1:0]      rsp_pos_x,
   output logic signed [OUT_W-1:0]      rsp_pos_y,
   output logic signed [OUT_W-1:0]      rsp_extent_width,
   output logic signed [OUT_W-1:0]      rsp_extent_height,
   output logic                         rsp_last,
   // configuration port
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [ADDR_W-1:0]       paddr,
   input  wire logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]            prdata,
   output logic                         pready
);

   cfg_type  cfg;
   push_type push;
   logic     room;
   res_type  rsp;

   // configuration registers
   tllw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // layout step
   tllw_engine #(
      .POS_BITS (POS_BITS)
   ) u_engine (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_glyph_code       (req_glyph_code),
      .req_glyph_known      (req_glyph_known),
      .req_glyph_trim_width (req_glyph_trim_width),
      .room                 (room),
      .push                 (push)
   );

   // result queue
   tllw_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   // result fields
   assign rsp_kind_res       = rsp.kind_res;
   assign rsp_glyph_code_res = rsp.glyph_code;
   assign rsp_pos_x          = rsp.pos_x;
   assign rsp_pos_y          = rsp.pos_y;
   assign rsp_extent_width   = rsp.extent_width;
   assign rsp_extent_height  = rsp.extent_height;
   assign rsp_last           = rsp.last;

endmodule
`default_nettype wire

/* tb/text_line_layout_wrap_clip_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_layout_wrap_clip_tb
// Self-checking bench for the greedy text line layout block. A clocked driver
// feeds character, newline, end-of-text and ignored-kind requests from a queue, a clocked
// monitor predicts pen, wrap and clip behavior for every accepted request and
// checks each result in order. Settings change between texts over the APB port,
// with random stalls on both channels and one long result stall.
// ----------------------------------------------------------------------------
module text_line_layout_wrap_clip_tb
   import tllw_pkg::*;
();

   localparam int     POS_BITS        = POS_BITS_DEF;
   localparam longint POS_MAX         = (longint'(1) <<< (POS_BITS - 1)) - 1;
   localparam longint POS_MIN         = -POS_MAX - 1;
   localparam int     CODE_MAX        = 1114111;
   localparam int     IDLE_LIMIT      = 4000;
   localparam int     LONG_HOLD       = 400;
   localparam int     RAND_PHASES     = 10;
   localparam int     ITEMS_PER_PHASE = 60;
   localparam int     REPORT_MAX      = 10;

   // kind code the block ignores
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [CODE_W-1:0] code;
      logic              known;
      logic [15:0]       trim;
   } text_item_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic              req_valid            = 1'b0;
   logic              req_ready;
   logic [1:0]        req_kind             = '0;
   logic [CODE_W-1:0] req_glyph_code       = '0;
   logic              req_glyph_known      = 1'b0;
   logic [15:0]       req_glyph_trim_width = '0;

   // result channel
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_kind_res;
   logic [CODE_W-1:0]       rsp_glyph_code_res;
   logic signed [OUT_W-1:0] rsp_pos_x;
   logic signed [OUT_W-1:0] rsp_pos_y;
   logic signed [OUT_W-1:0] rsp_extent_width;
   logic signed [OUT_W-1:0] rsp_extent_height;
   logic                    rsp_last;

   // configuration port
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [ADDR_W-1:0] paddr   = '0;
   logic [DATA_W-1:0] pwdata  = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // stimulus and prediction state
   text_item_type text_pending[$];
   res_type  layout_expect[$];
   cfg_type  layout_cfg;
   logic signed [POS_BITS-1:0] pen_x   = '0;
   logic signed [POS_BITS-1:0] pen_y   = '0;
   logic signed [POS_BITS-1:0] widest  = '0;
   logic                       has_glyph = 1'b0;
   logic                       stopped   = 1'b0;

   logic req_fire   = 1'b0;
   bit   quiet      = 1'b0;
   bit   hold_arm   = 1'b0;
   bit   hold_done  = 1'b0;
   int   hold_cnt   = 0;
   int   send_gap   = 0;
   int   recv_gap   = 0;
   int   fail_count = 0;
   int   report_cnt = 0;

   text_line_layout_wrap_clip #(.POS_BITS(POS_BITS)) i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_glyph_code       (req_glyph_code),
      .req_glyph_known      (req_glyph_known),
      .req_glyph_trim_width (req_glyph_trim_width),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind_res         (rsp_kind_res),
      .rsp_glyph_code_res   (rsp_glyph_code_res),
      .rsp_pos_x            (rsp_pos_x),
      .rsp_pos_y            (rsp_pos_y),
      .rsp_extent_width     (rsp_extent_width),
      .rsp_extent_height    (rsp_extent_height),
      .rsp_last             (rsp_last),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // layout predictor
   // ---------------------------------------------------------------------

   function automatic logic signed [POS_BITS-1:0] sat_pos(input longint v);
      if (v > POS_MAX) return POS_MAX[POS_BITS-1:0];
      if (v < POS_MIN) return POS_MIN[POS_BITS-1:0];
      return v[POS_BITS-1:0];
   endfunction

   function automatic longint spacing_x_val();
      return longint'($signed(layout_cfg.spacing_x));
   endfunction

   function automatic longint spacing_y_val();
      return longint'($signed(layout_cfg.spacing_y));
   endfunction

   // current line bottom below the area with clip on
   function automatic bit line_will_drop();
      return layout_cfg.layout_mode[MODE_CLIP] &&
             (longint'(pen_y) + longint'(layout_cfg.line_height) >
              longint'(layout_cfg.area_height));
   endfunction

   // close the current line, returns 1 with the line result when it is kept
   function automatic bit close_line(output res_type line_res);
      logic signed [POS_BITS-1:0] w;
      line_res = '0;
      if (stopped) return 1'b0;
      if (line_will_drop()) begin
         stopped = 1'b1;
         return 1'b0;
      end
      w = has_glyph ? sat_pos(longint'(pen_x) - spacing_x_val()) : pen_x;
      line_res.kind_res     = RES_LINE;
      line_res.pos_y        = pen_y;
      line_res.extent_width = w;
      if (w > widest) widest = w;
      pen_x = '0;
      pen_y = sat_pos(longint'(pen_y) + longint'(layout_cfg.line_height) + spacing_y_val());
      has_glyph = 1'b0;
      return 1'b1;
   endfunction

   // expected results of one accepted request
   task automatic predict_layout(input logic [1:0] kind, input logic [CODE_W-1:0] code,
                                 input logic known, input logic [15:0] trim);
      res_type produced[2];
      res_type r;
      int      cnt;
      longint  adv;
      bit      placed;
      cnt = 0;
      case (kind)
         KIND_CHAR: begin
            if (!stopped) begin
               if (known)
                  adv = ((longint'(trim) * longint'(layout_cfg.width_scale) + 128) >>> 8)
                        + spacing_x_val();
               else
                  adv = longint'(layout_cfg.char_width) + spacing_x_val();
               placed = 1'b1;
               // wrap closes the line first
               if (layout_cfg.layout_mode[MODE_WRAP] &&
                   longint'(pen_x) + adv > longint'(layout_cfg.area_width)) begin
                  placed = close_line(r);
                  if (placed) begin
                     produced[cnt] = r;
                     cnt++;
                  end
               end
               if (placed) begin
                  if (known) begin
                     has_glyph = 1'b1;
                     if (!line_will_drop()) begin
                        r            = '0;
                        r.kind_res   = RES_GLYPH;
                        r.glyph_code = code;
                        r.pos_x      = pen_x;
                        r.pos_y      = pen_y;
                        produced[cnt] = r;
                        cnt++;
                     end
                  end
                  pen_x = sat_pos(longint'(pen_x) + adv);
               end
            end
         end
         KIND_NEWLINE: begin
            if (close_line(r)) begin
               produced[cnt] = r;
               cnt++;
            end
         end
         KIND_END: begin
            if (close_line(r)) begin
               produced[cnt] = r;
               cnt++;
            end
            r               = '0;
            r.kind_res      = RES_REGION;
            r.extent_width  = widest;
            r.extent_height = sat_pos(longint'(pen_y) - spacing_y_val());
            produced[cnt] = r;
            cnt++;
            // re-arm for the next text
            pen_x     = '0;
            pen_y     = '0;
            widest    = '0;
            has_glyph = 1'b0;
            stopped   = 1'b0;
         end
         default: ;
      endcase
      for (int i = 0; i < cnt; i++) begin
         if (i == cnt - 1) produced[i].last = 1'b1;
         layout_expect = {layout_expect, produced[i]};
      end
   endtask

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : sender
      text_item_type next_item;
      if (!reset && (!req_valid || req_fire)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (text_pending.size() != 0 && !quiet && $urandom_range(0, 15) == 0) begin
            send_gap = $urandom_range(0, 18);
            req_valid <= 1'b0;
         end else if (text_pending.size() != 0) begin
            next_item = text_pending.pop_front();
            req_kind             <= next_item.kind;
            req_glyph_code       <= next_item.code;
            req_glyph_known      <= next_item.known;
            req_glyph_trim_width <= next_item.trim;
            req_valid            <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result ready with random stalls and one long hold-off
   always @(negedge clock) begin : receiver
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_done = 1'b1;
         hold_cnt  = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
         recv_gap = $urandom_range(0, 18);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: check results, predict accepted requests
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      res_type seen;
      res_type want;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen.kind_res      = rsp_kind_res;
            seen.glyph_code    = rsp_glyph_code_res;
            seen.pos_x         = rsp_pos_x;
            seen.pos_y         = rsp_pos_y;
            seen.extent_width  = rsp_extent_width;
            seen.extent_height = rsp_extent_height;
            seen.last          = rsp_last;
            if (layout_expect.size() == 0) begin
               fail_count++;
               if (report_cnt < REPORT_MAX) begin
                  report_cnt++;
                  $display("[%0t] result with nothing expected: kind %0d code %0d", $time,
                           seen.kind_res, seen.glyph_code);
               end
            end else begin
               want = layout_expect.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  if (report_cnt < REPORT_MAX) begin
                     report_cnt++;
                     $display("[%0t] mismatch", $time);
                     $display("  expected: kind %0d code %0d x %0d y %0d w %0d h %0d last %0d",
                              want.kind_res, want.glyph_code, want.pos_x, want.pos_y,
                              want.extent_width, want.extent_height, want.last);
                     $display("  actual:   kind %0d code %0d x %0d y %0d w %0d h %0d last %0d",
                              seen.kind_res, seen.glyph_code, seen.pos_x, seen.pos_y,
                              seen.extent_width, seen.extent_height, seen.last);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            predict_layout(req_kind, req_glyph_code, req_glyph_known, req_glyph_trim_width);
      end
   end

   // watchdog on cycles without any transfer
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   task automatic add_item(input logic [1:0] kind, input int code, input logic known,
                           input int trim);
      text_item_type it;
      it.kind  = kind;
      it.code  = code[CODE_W-1:0];
      it.known = known;
      it.trim  = trim[15:0];
      text_pending = {text_pending, it};
   endtask

   // wait until every request is taken and every result is back, then pause
   task automatic settle(input int pause);
      while (text_pending.size() != 0 || req_valid || layout_expect.size() != 0)
         @(posedge clock);
      repeat (pause) @(posedge clock);
   endtask

   // one APB write, setup then access
   task automatic cfg_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_CHAR_WIDTH:  layout_cfg.char_width  = value[15:0];
         REG_LINE_HEIGHT: layout_cfg.line_height = value[15:0];
         REG_SPACING_X:   layout_cfg.spacing_x   = value[15:0];
         REG_SPACING_Y:   layout_cfg.spacing_y   = value[15:0];
         REG_AREA_WIDTH:  layout_cfg.area_width  = value[22:0];
         REG_AREA_HEIGHT: layout_cfg.area_height = value[22:0];
         REG_WIDTH_SCALE: layout_cfg.width_scale = value[15:0];
         REG_LAYOUT_MODE: layout_cfg.layout_mode = value[1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input int cw, input int lh, input int sx, input int sy,
                            input int aw, input int ah, input int scale, input int mode);
      cfg_write(REG_CHAR_WIDTH, cw);
      cfg_write(REG_LINE_HEIGHT, lh);
      cfg_write(REG_SPACING_X, sx);
      cfg_write(REG_SPACING_Y, sy);
      cfg_write(REG_AREA_WIDTH, aw);
      cfg_write(REG_AREA_HEIGHT, ah);
      cfg_write(REG_WIDTH_SCALE, scale);
      cfg_write(REG_LAYOUT_MODE, mode);
   endtask

   // unsigned setting: extremes now and then, else a typical range
   function automatic int pick_u(input int top, input int lo, input int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return top;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic int pick_s(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return -32768;
      if (r == 1) return 32767;
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   // settings of one random phase, all-minimum and all-maximum first
   task automatic random_settings(input int phase, output int trim_hi);
      if (phase == 0) begin
         write_all(0, 0, -32768, -32768, 0, 0, 0, 3);
         trim_hi = 512;
      end else if (phase == 1) begin
         write_all(65535, 65535, 32767, 32767, 8388607, 8388607, 65535, 3);
         trim_hi = 65535;
      end else begin
         write_all(pick_u(65535, 64, 512), pick_u(65535, 64, 512), pick_s(-32, 64),
                   pick_s(-32, 64), pick_u(8388607, 256, 4096), pick_u(8388607, 256, 4096),
                   pick_u(65535, 64, 512), $urandom_range(0, 3));
         trim_hi = 512;
      end
   endtask

   // one random text, mostly characters, ended by end of text most of the time
   task automatic queue_random_text(input int trim_hi, inout int counted);
      text_item_type it;
      int       n;
      int       r;
      n = $urandom_range(1, 30);
      repeat (n) begin
         it.code  = $urandom_range(0, 1) ? CODE_W'($urandom_range(0, 127))
                                         : CODE_W'($urandom_range(0, CODE_MAX));
         it.known = ($urandom_range(0, 3) != 0);
         it.trim  = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65535))
                                                 : 16'($urandom_range(0, trim_hi));
         r = $urandom_range(0, 39);
         if (r < 4)
            it.kind = KIND_NEWLINE;
         else if (r == 4)
            it.kind = KIND_UNUSED;
         else
            it.kind = KIND_CHAR;
         text_pending = {text_pending, it};
         if (it.kind != KIND_UNUSED) counted++;
      end
      if ($urandom_range(0, 7) != 0) begin
         add_item(KIND_END, $urandom_range(0, CODE_MAX), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 65535));
         counted++;
      end
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      int phase_items;
      int trim_hi;
      // register values after reset
      layout_cfg.char_width  = 16'd256;
      layout_cfg.line_height = 16'd256;
      layout_cfg.spacing_x   = 16'sd0;
      layout_cfg.spacing_y   = 16'sd0;
      layout_cfg.area_width  = 23'd4096;
      layout_cfg.area_height = 23'd4096;
      layout_cfg.width_scale = 16'd256;
      layout_cfg.layout_mode = 2'd0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // defaults: field extremes, empty line, ignored kind
      add_item(KIND_CHAR, 0, 1'b1, 0);
      add_item(KIND_CHAR, CODE_MAX, 1'b1, 65535);
      add_item(KIND_CHAR, 'h155555, 1'b0, 'hAAAA);
      add_item(KIND_NEWLINE, 'h0AAAAA, 1'b1, 'h5555);
      add_item(KIND_NEWLINE, 0, 1'b0, 0);
      add_item(KIND_UNUSED, CODE_MAX, 1'b1, 65535);
      add_item(KIND_END, 0, 1'b0, 0);
      settle(8);

      // small area with wrap and clip: wrap with glyph, dropped line, stopped layout
      write_all(300, 256, 16, -16, 1024, 600, 65535, (1 << MODE_WRAP) | (1 << MODE_CLIP));
      add_item(KIND_CHAR, 'h41, 1'b1, 2);
      add_item(KIND_CHAR, 'h42, 1'b1, 2);
      add_item(KIND_CHAR, 'h43, 1'b0, 2);
      add_item(KIND_NEWLINE, 0, 1'b0, 0);
      add_item(KIND_CHAR, 'h44, 1'b1, 1);
      add_item(KIND_NEWLINE, 0, 1'b0, 0);
      add_item(KIND_CHAR, 'h45, 1'b1, 1);
      add_item(KIND_NEWLINE, 0, 1'b0, 0);
      add_item(KIND_END, 0, 1'b0, 0);
      settle(8);

      // pen saturation at the top of the position range
      cfg_write(REG_WIDTH_SCALE, 65535);
      cfg_write(REG_SPACING_X, 32767);
      cfg_write(REG_LAYOUT_MODE, 0);
      add_item(KIND_CHAR, 'h100000, 1'b1, 65535);
      add_item(KIND_CHAR, 'h0FFFFF, 1'b1, 65535);
      add_item(KIND_CHAR, 'h7F, 1'b0, 0);
      add_item(KIND_NEWLINE, 0, 1'b0, 0);
      add_item(KIND_END, 0, 1'b0, 0);
      settle(8);

      // random texts under changing settings
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph == RAND_PHASES - 1) quiet = 1'b1;
         random_settings(ph, trim_hi);
         phase_items = 0;
         while (phase_items < ITEMS_PER_PHASE) queue_random_text(trim_hi, phase_items);
         add_item(KIND_END, 0, 1'b0, 0);
         // long result stall while requests keep coming
         if (ph == 3) hold_arm = 1'b1;
         settle(8);
      end

      settle(20);
      if (fail_count == 0 && layout_expect.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
hdl/tllw_pkg.sv
hdl/tllw_csr.sv
hdl/tllw_engine.sv
hdl/tllw_rsp_fifo.sv
hdl/text_line_layout_wrap_clip.sv
tb/text_line_layout_wrap_clip_tb.sv
